// ===== rtl/core/arp_pkg.sv =====
package arp_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [10:0] MIN_ARP_LEN = 11'd28;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN      = 8'd6;
    localparam logic [7:0]  PROTO_LEN   = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;

    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Register index as decoded from paddr[3].
    localparam logic REG_LOCAL_IP  = 1'b0;
    localparam logic REG_LOCAL_MAC = 1'b1;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

    // Input item fields, first field in the highest bits.
    typedef struct packed {
        logic [31:0] lookup_ip;
        logic [31:0] tpa;
        logic [31:0] spa;
        logic [47:0] sha;
        logic [15:0] opcode;
        logic [7:0]  psize;
        logic [7:0]  hw_size;
        logic [15:0] ptype;
        logic [15:0] hw_type;
        logic [10:0] payload_len;
    } in_item_t;

    typedef struct packed {
        logic [31:0] reply_dest_ip;
        logic [47:0] reply_dest_mac;
        logic        send_reply;
        logic [47:0] found_mac;
        logic        lookup_hit;
        logic        packet_accepted;
    } out_item_t;

    localparam int IN_ITEM_W  = $bits(in_item_t);
    localparam int OUT_ITEM_W = $bits(out_item_t);
    localparam int S_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((OUT_ITEM_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== rtl/core/arp_cache_and_reply_engine.sv =====
// ARP binding cache and reply detector.
// Items enter on the s_ stream: s_tuser selects a received ARP packet (0)
// or a lookup (1), s_tdata carries the packet fields and the lookup address.
// Every item yields exactly one result on the m_ stream.
// Local IP and MAC are written through the APB port at byte addresses 0 and 8.
// One item is handled at a time. A packet that fails the length or format
// checks skips the scan and gets an all-zero result. Any other item
// scans the binding memory one entry per cycle through its single read port,
// stopping at the first valid match; a packet's binding is written back on
// the final scan cycle.
// The result sits in an output register; s_tready rises again as soon as the
// result is loaded, so the next item may enter while it waits to be taken.
// If m_tready stays low, a second finished result waits inside the block
// and no further item is taken until the output register frees.
// Reset clears the valid marks, the replacement cursor and both registers at
// once; there is no clearing pass, and the block is ready the cycle after.
module arp_cache_and_reply_engine #(
    parameter int ENTRIES = arp_pkg::ENTRIES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata, lowest bit up: payload_len, hw_type, ptype, hw_size,
    // psize, opcode, sha, spa, tpa, lookup_ip
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [arp_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: req_type
    input  logic                            s_tuser,
    // m_tdata, lowest bit up: packet_accepted, lookup_hit, found_mac,
    // send_reply, reply_dest_mac, reply_dest_ip
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [arp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [arp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [arp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

    // Configuration registers.
    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_ip_reg  <= '0;
            local_mac_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                arp_pkg::REG_LOCAL_IP:  local_ip_reg  <= pwdata[31:0];
                arp_pkg::REG_LOCAL_MAC: local_mac_reg <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            arp_pkg::REG_LOCAL_IP:  prdata = {32'd0, local_ip_reg};
            arp_pkg::REG_LOCAL_MAC: prdata = {16'd0, local_mac_reg};
            default:                prdata = '0;
        endcase
    end

    // Item handling.
    arp_pkg::in_item_t  in_item;
    arp_pkg::out_item_t res_next, res_reg;
    arp_pkg::out_item_t out_next, out_reg;
    arp_pkg::state_t    state_reg, state_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 lookup_reg, lookup_next;
    logic                 reply_reg, reply_next;
    logic [31:0]          key_reg, key_next;
    logic [47:0]          smac_reg, smac_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]     cursor_reg, cursor_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;

    logic                 in_accept;
    logic                 pkt_ok;
    logic                 hit;
    logic                 scan_end;
    logic [IDX_W-1:0]     slot;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    logic [arp_pkg::ENTRY_W-1:0] ram_wdata;
    logic [arp_pkg::ENTRY_W-1:0] ram_rdata;
    logic [31:0]          rd_ip;
    logic [47:0]          rd_mac;

    assign in_item   = arp_pkg::in_item_t'(s_tdata[arp_pkg::IN_ITEM_W-1:0]);
    assign s_tready  = (state_reg == arp_pkg::ST_IDLE);
    assign in_accept = s_tvalid & s_tready;

    assign pkt_ok = (in_item.payload_len >= arp_pkg::MIN_ARP_LEN)
                  && (in_item.hw_type == arp_pkg::HW_ETHERNET)
                  && (in_item.ptype == arp_pkg::PROTO_IPV4)
                  && (in_item.hw_size == arp_pkg::HW_LEN)
                  && (in_item.psize == arp_pkg::PROTO_LEN);

    assign rd_ip  = ram_rdata[arp_pkg::ENTRY_W-1 -: arp_pkg::IP_W];
    assign rd_mac = ram_rdata[arp_pkg::MAC_W-1:0];

    // Invalid entries are never compared: their contents are undefined.
    assign hit      = chk_vld_reg && valid_reg[chk_idx_reg] && (rd_ip == key_reg);
    assign scan_end = chk_vld_reg && (chk_idx_reg == LAST_IDX);
    assign slot     = free_found_reg ? free_idx_reg : cursor_reg;

    assign ram_raddr = rd_cnt_reg[IDX_W-1:0];
    assign ram_wdata = {key_reg, smac_reg};

    always_comb begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        res_next        = res_reg;
        lookup_next     = lookup_reg;
        reply_next      = reply_reg;
        key_next        = key_reg;
        smac_next       = smac_reg;
        rd_cnt_next     = rd_cnt_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = 1'b0;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        cursor_next     = cursor_reg;
        valid_next      = valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            arp_pkg::ST_IDLE: begin
                if (in_accept) begin
                    lookup_next     = (s_tuser == arp_pkg::REQ_LOOKUP);
                    key_next        = (s_tuser == arp_pkg::REQ_LOOKUP) ?
                                      in_item.lookup_ip : in_item.spa;
                    smac_next       = in_item.sha;
                    reply_next      = (in_item.opcode == arp_pkg::OP_REQUEST)
                                    && (local_ip_reg != 32'd0)
                                    && (in_item.tpa == local_ip_reg);
                    rd_cnt_next     = '0;
                    free_found_next = 1'b0;
                    res_next        = '0;
                    if ((s_tuser == arp_pkg::REQ_LOOKUP) || pkt_ok) begin
                        state_next = arp_pkg::ST_SCAN;
                    end else begin
                        state_next = arp_pkg::ST_DONE;
                    end
                end
            end
            arp_pkg::ST_SCAN: begin
                // Issue one read per cycle; each compare runs in the cycle after its read.
                if (rd_cnt_reg < CNT_END) begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                end
                if (chk_vld_reg && !valid_reg[chk_idx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = chk_idx_reg;
                end
                if (hit || scan_end) begin
                    state_next   = arp_pkg::ST_DONE;
                    chk_vld_next = 1'b0;
                    if (lookup_reg) begin
                        res_next.lookup_hit = hit;
                        res_next.found_mac  = hit ? rd_mac : 48'd0;
                    end else begin
                        res_next.packet_accepted = 1'b1;
                        res_next.send_reply      = reply_reg;
                        res_next.reply_dest_mac  = reply_reg ? smac_reg : 48'd0;
                        res_next.reply_dest_ip   = reply_reg ? key_reg : 32'd0;
                        ram_we = 1'b1;
                        if (hit) begin
                            ram_waddr = chk_idx_reg;
                        end else begin
                            // The last entry may be the first free one.
                            if (!valid_reg[chk_idx_reg] && !free_found_reg) begin
                                ram_waddr = chk_idx_reg;
                            end else begin
                                ram_waddr = slot;
                                if (!free_found_reg) begin
                                    cursor_next = (cursor_reg == LAST_IDX) ?
                                                  '0 : cursor_reg + IDX_W'(1);
                                end
                            end
                            valid_next[ram_waddr] = 1'b1;
                        end
                    end
                end
            end
            arp_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = arp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = arp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= arp_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            chk_vld_reg    <= 1'b0;
            cursor_reg     <= '0;
            valid_reg      <= '0;
            free_found_reg <= 1'b0;
            rd_cnt_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            chk_vld_reg    <= chk_vld_next;
            cursor_reg     <= cursor_next;
            valid_reg      <= valid_next;
            free_found_reg <= free_found_next;
            rd_cnt_reg     <= rd_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        res_reg      <= res_next;
        lookup_reg   <= lookup_next;
        reply_reg    <= reply_next;
        key_reg      <= key_next;
        smac_reg     <= smac_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
    end

    arp_ram #(
        .WIDTH (arp_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = arp_pkg::M_TDATA_W'(out_reg);

endmodule

// ===== rtl/core/arp_ram.sv =====
module arp_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arp_pkg::*;

    localparam logic [15:0] OP_REPLY = 16'h0002;
    localparam int SETTLE_CYCLES = ENTRIES_DEFAULT + 14;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_SIZE = 24;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the binding table and the local address.
    logic [IP_W-1:0]  bind_ip    [ENTRIES_DEFAULT];
    logic [MAC_W-1:0] bind_mac   [ENTRIES_DEFAULT];
    logic             bind_valid [ENTRIES_DEFAULT];
    int               rr_cursor;
    logic [IP_W-1:0]  cfg_local_ip;

    out_item_t outcome_queue[$];
    out_item_t got_item;
    out_item_t want_item;
    int        mismatches;
    int        src_gap_pct;
    int        sink_stall_pct;
    logic      hold_sink;
    int        quiet_cycles;

    arp_cache_and_reply_engine #(.ENTRIES(ENTRIES_DEFAULT)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[MAC_W-1:0];
    endfunction

    function automatic int find_binding(logic [IP_W-1:0] ip);
        for (int i = 0; i < ENTRIES_DEFAULT; i++) begin
            if (bind_valid[i] && bind_ip[i] == ip)
                return i;
        end
        return -1;
    endfunction

    // Works out the result of one item and updates the shadow table.
    function automatic out_item_t cache_outcome(logic kind, in_item_t it);
        out_item_t r;
        int slot;
        r = '0;
        if (kind == REQ_LOOKUP) begin
            slot = find_binding(it.lookup_ip);
            if (slot >= 0) begin
                r.lookup_hit = 1'b1;
                r.found_mac = bind_mac[slot];
            end
            return r;
        end
        if (it.payload_len < MIN_ARP_LEN || it.hw_type != HW_ETHERNET ||
            it.ptype != PROTO_IPV4 || it.hw_size != HW_LEN ||
            it.psize != PROTO_LEN)
            return r;
        slot = find_binding(it.spa);
        if (slot < 0) begin
            // Lowest free entry first; the cursor only moves when the table is full.
            for (int i = ENTRIES_DEFAULT - 1; i >= 0; i--) begin
                if (!bind_valid[i])
                    slot = i;
            end
            if (slot < 0) begin
                slot = rr_cursor;
                rr_cursor = (rr_cursor + 1) % ENTRIES_DEFAULT;
            end
            bind_ip[slot] = it.spa;
            bind_valid[slot] = 1'b1;
        end
        bind_mac[slot] = it.sha;
        r.packet_accepted = 1'b1;
        if (it.opcode == OP_REQUEST && cfg_local_ip != '0 && it.tpa == cfg_local_ip) begin
            r.send_reply = 1'b1;
            r.reply_dest_mac = it.sha;
            r.reply_dest_ip = it.spa;
        end
        return r;
    endfunction

    function automatic in_item_t good_packet(logic [IP_W-1:0] sip, logic [MAC_W-1:0] smac,
                                             logic [IP_W-1:0] tip, logic [15:0] op,
                                             logic [10:0] len);
        in_item_t it;
        it.payload_len = len;
        it.hw_type = HW_ETHERNET;
        it.ptype = PROTO_IPV4;
        it.hw_size = HW_LEN;
        it.psize = PROTO_LEN;
        it.opcode = op;
        it.sha = smac;
        it.spa = sip;
        it.tpa = tip;
        it.lookup_ip = $urandom;
        return it;
    endfunction

    function automatic in_item_t noise_item();
        logic [S_TDATA_W-1:0] junk;
        junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return in_item_t'(junk[IN_ITEM_W-1:0]);
    endfunction

    function automatic in_item_t lookup_item(logic [IP_W-1:0] ip);
        in_item_t it;
        it = noise_item();
        it.lookup_ip = ip;
        return it;
    endfunction

    task automatic push_item(input logic kind, input in_item_t it);
        if ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(S_TDATA_W - IN_ITEM_W){1'b0}}, it};
        do @(posedge aclk); while (!s_tready);
        outcome_queue.push_back(cache_outcome(kind, it));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (outcome_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers back to back; the block must be idle.
    task automatic apb_program(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_LOCAL_IP, 3'b000};
        pwdata <= {32'b0, ip};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cfg_local_ip = ip;
        penable <= 1'b0;
        paddr <= {REG_LOCAL_MAC, 3'b000};
        pwdata <= {16'b0, mac};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_directed();
        in_item_t it;
        logic [IP_W-1:0] far_ip;
        far_ip = 32'hC0A8_0A02;
        apb_program(32'hC0A8_0A01, '0);
        push_item(REQ_LOOKUP, lookup_item(far_ip));
        push_item(REQ_PACKET, good_packet('1, '1, cfg_local_ip, OP_REQUEST, MIN_ARP_LEN));
        push_item(REQ_LOOKUP, lookup_item('1));
        // Same sender again with a new MAC: updated in place.
        push_item(REQ_PACKET, good_packet('1, '0, cfg_local_ip, OP_REQUEST, '1));
        push_item(REQ_LOOKUP, lookup_item('1));
        push_item(REQ_PACKET, good_packet('0, rand_mac(), cfg_local_ip, OP_REPLY, 11'd60));
        push_item(REQ_PACKET, good_packet(32'h0102_0304, rand_mac(), cfg_local_ip ^ 32'h1,
                                          OP_REQUEST, 11'd42));
        push_item(REQ_PACKET, good_packet(32'h0102_0305, rand_mac(), cfg_local_ip, '1, 11'd42));
        push_item(REQ_PACKET, good_packet(32'h0102_0306, rand_mac(), cfg_local_ip, '0, 11'd42));
        // Malformed packets from an unknown sender must leave no trace.
        it = good_packet(far_ip, rand_mac(), cfg_local_ip, OP_REQUEST, MIN_ARP_LEN - 11'd1);
        push_item(REQ_PACKET, it);
        it.payload_len = '0;
        push_item(REQ_PACKET, it);
        it.payload_len = MIN_ARP_LEN;
        it.hw_type = '0;
        push_item(REQ_PACKET, it);
        it.hw_type = '1;
        push_item(REQ_PACKET, it);
        it.hw_type = HW_ETHERNET;
        it.ptype = 16'h0806;
        push_item(REQ_PACKET, it);
        it.ptype = PROTO_IPV4;
        it.hw_size = 8'd5;
        push_item(REQ_PACKET, it);
        it.hw_size = '1;
        push_item(REQ_PACKET, it);
        it.hw_size = HW_LEN;
        it.psize = '0;
        push_item(REQ_PACKET, it);
        it.psize = '1;
        push_item(REQ_PACKET, it);
        push_item(REQ_LOOKUP, lookup_item(far_ip));
        push_item(REQ_LOOKUP, lookup_item('0));
        drain();
        // A zero local address turns replies off, even for a zero target.
        apb_program('0, '1);
        push_item(REQ_PACKET, good_packet(far_ip, rand_mac(), '0, OP_REQUEST, MIN_ARP_LEN));
        drain();
        apb_program('1, '0);
        push_item(REQ_PACKET, good_packet(32'h0A0B_0C0D, rand_mac(), '1, OP_REQUEST, 11'd28));
        push_item(REQ_LOOKUP, lookup_item(far_ip));
        drain();
    endtask

    // Fills the table past its size so that the replacement cursor is used.
    task automatic test_replacement();
        for (int n = 0; n < 18; n++)
            push_item(REQ_PACKET, good_packet(32'h0A00_0000 + n, rand_mac(), '0, OP_REPLY, 11'd46));
        for (int n = 0; n < 8; n++)
            push_item(REQ_LOOKUP, lookup_item(32'h0A00_0000 + $urandom_range(19)));
        drain();
    endtask

    task automatic test_backpressure();
        src_gap_pct = 0;
        hold_sink = 1'b1;
        for (int n = 0; n < 12; n++)
            push_item(REQ_PACKET, good_packet($urandom, rand_mac(), $urandom, OP_REQUEST, 11'd64));
        drain();
    endtask

    // Mostly well-formed packets and lookups over a small address pool, so that
    // hits, in-place updates and replacements are frequent; the rest is malformed or noise.
    task automatic run_random_traffic(input int count, input int gap_pct, input int stall_pct);
        logic [IP_W-1:0] pool [POOL_SIZE];
        logic [IP_W-1:0] tip;
        logic [15:0] op;
        in_item_t it;
        int pick;
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        foreach (pool[i])
            pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                tip = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
                push_item(REQ_LOOKUP, lookup_item(tip));
            end else begin
                tip = ($urandom_range(99) < 45) ? cfg_local_ip : $urandom;
                pick = $urandom_range(9);
                op = (pick < 6) ? OP_REQUEST : (pick < 9) ? OP_REPLY : 16'($urandom);
                it = good_packet(pool[$urandom_range(POOL_SIZE - 1)], rand_mac(), tip, op,
                                 11'($urandom_range(2047, 28)));
                if ($urandom_range(99) < 25) begin
                    case ($urandom_range(5))
                        0: it.payload_len = 11'($urandom_range(27));
                        1: it.hw_type = 16'($urandom);
                        2: it.ptype = 16'($urandom);
                        3: it.hw_size = 8'($urandom);
                        4: it.psize = 8'($urandom);
                        default: it = noise_item();
                    endcase
                end
                push_item(REQ_PACKET, it);
            end
        end
        drain();
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_item = out_item_t'(m_tdata[OUT_ITEM_W-1:0]);
            if (outcome_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got_item);
                mismatches++;
            end else begin
                want_item = outcome_queue.pop_front();
                report_field("packet_accepted", want_item.packet_accepted,
                             got_item.packet_accepted);
                report_field("lookup_hit", want_item.lookup_hit, got_item.lookup_hit);
                report_field("found_mac", want_item.found_mac, got_item.found_mac);
                report_field("send_reply", want_item.send_reply, got_item.send_reply);
                report_field("reply_dest_mac", want_item.reply_dest_mac,
                             got_item.reply_dest_mac);
                report_field("reply_dest_ip", want_item.reply_dest_ip, got_item.reply_dest_ip);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                hold_sink = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        foreach (bind_valid[i]) begin
            bind_valid[i] = 1'b0;
            bind_ip[i] = '0;
            bind_mac[i] = '0;
        end
        rr_cursor = 0;
        cfg_local_ip = '0;
        mismatches = 0;
        hold_sink = 1'b0;
        src_gap_pct = 6;
        sink_stall_pct = 88;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= REQ_PACKET;
        s_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_replacement();
        apb_program($urandom | 32'h1, '1);
        run_random_traffic(490, 6, 88);
        test_backpressure();
        apb_program($urandom | 32'h1, '0);
        run_random_traffic(490, 88, 6);
        apb_program($urandom | 32'h1, rand_mac());
        run_random_traffic(490, 0, 0);

        if (mismatches == 0 && outcome_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== arp_cache_and_reply_engine.f =====
rtl/core/arp_pkg.sv
rtl/core/arp_ram.sv
rtl/core/arp_cache_and_reply_engine.sv
test/tb.sv
